@@ rtl/core/sat_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants for the section address translator: table depth,
// command and register codes, sequencer states and the shared ALU interface.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int NUM_REGIONS = 64;
    localparam int IDX_W       = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int CNT_W       = $clog2(NUM_REGIONS + 1);
    localparam int ADDR_W      = 64;
    localparam int COUNT_W     = 7;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_V2F  = 2'd1,
        CMD_F2V  = 2'd2
    } t_cmd;

    typedef enum logic {
        REG_IMAGE_OFFSET = 1'b0,
        REG_REGION_COUNT = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BIAS,
        ST_SCAN,
        ST_ADD
    } t_state;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [ADDR_W-1:0]   a;
        logic [ADDR_W-1:0]   b;
        logic [ADDR_W-1:0]   c;
    } t_alu_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   sum;
        logic                carry;
        logic                below;
    } t_alu_res;

endpackage
`default_nettype wire

@@ rtl/core/sat_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sat_alu
// Shared 64-bit add/subtract unit with a trailing magnitude compare. On a
// subtraction, carry high means no borrow; below compares the sum with c.
// ----------------------------------------------------------------------------
module sat_alu (
    input  sat_pkg::t_alu_req i_req,
    output sat_pkg::t_alu_res o_res
);

    logic [sat_pkg::ADDR_W-1:0] operand_b;
    logic                       carry_in;
    logic [sat_pkg::ADDR_W:0]   total;

    always_comb begin
        if (i_req.op == sat_pkg::ALU_SUB) begin
            operand_b = ~i_req.b;
            carry_in  = 1'b1;
        end else begin
            operand_b = i_req.b;
            carry_in  = 1'b0;
        end
        total = {1'b0, i_req.a} + {1'b0, operand_b}
                + {{sat_pkg::ADDR_W{1'b0}}, carry_in};
        o_res.sum   = total[sat_pkg::ADDR_W-1:0];
        o_res.carry = total[sat_pkg::ADDR_W];
        o_res.below = (total[sat_pkg::ADDR_W-1:0] < i_req.c);
    end

endmodule
`default_nettype wire

@@ rtl/core/section_address_translate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// section_address_translate
// Region table with virtual-to-file and file-to-virtual address translation.
//
//   Channel   Ports                                      Handshake
//   command   i_command, i_entry_*, i_address            i_start && !o_busy
//   result    o_ok, o_translated_address                 o_done, one cycle
//   config    i_cfg_index, i_cfg_data                    i_cfg_valid && o_cfg_ready
//
// A load or an unknown command gives its result in the cycle after acceptance and
// leaves the block free. A query scans the table one entry per cycle through a
// single subtract-and-compare unit, so o_busy stays high while it runs, over up to
// min(region_count, 64) entries, and falls in the cycle that o_done rises.
// Configuration writes are held off while a transaction is being accepted or
// processed. Reset is synchronous and empties the table at once through the
// per-entry allocated flags. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module section_address_translate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_command,
    input  logic [5:0]                     i_entry_index,
    input  logic [63:0]                    i_entry_start,
    input  logic [63:0]                    i_entry_size,
    input  logic                           i_entry_alloc,
    input  logic [63:0]                    i_address,
    output logic                           o_done,
    output logic                           o_ok,
    output logic [63:0]                    o_translated_address,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);

    localparam int IW = sat_pkg::IDX_W;
    localparam int CW = sat_pkg::CNT_W;
    localparam int AW = sat_pkg::ADDR_W;

    sat_pkg::t_state          r_state, n_state;
    sat_pkg::t_cmd            r_cmd, n_cmd;
    logic [CW-1:0]            r_k, n_k;
    logic [CW-1:0]            r_limit, n_limit;
    logic                     r_pend, n_pend;
    logic                     r_pend_alloc;
    logic [AW-1:0]            r_faddr, n_faddr;
    logic [AW-1:0]            r_addr, n_addr;
    logic                     r_done, n_done;
    logic                     r_ok, n_ok;
    logic [AW-1:0]            r_taddr, n_taddr;
    logic [AW-1:0]            r_image_offset;
    logic [sat_pkg::COUNT_W-1:0] r_region_count;

    logic [2*AW-1:0]          r_mem [sat_pkg::NUM_REGIONS];
    logic [2*AW-1:0]          r_rd_data;
    logic [sat_pkg::NUM_REGIONS-1:0] r_alloc;

    logic                     accept;
    logic                     in_range;
    logic                     mem_we;
    logic [IW-1:0]            wr_idx;
    logic [IW-1:0]            rd_idx;
    logic [CW-1:0]            limit;
    sat_pkg::t_alu_req        alu_req;
    sat_pkg::t_alu_res        alu_res;

    assign o_busy      = (r_state != sat_pkg::ST_IDLE);
    assign o_cfg_ready = !o_busy && !i_start;
    assign accept      = i_start && !o_busy;
    assign in_range    = (32'(i_entry_index) < sat_pkg::NUM_REGIONS);
    assign wr_idx      = IW'(i_entry_index);
    assign rd_idx      = r_k[IW-1:0];
    assign limit       = (32'(r_region_count) > sat_pkg::NUM_REGIONS)
                         ? CW'(sat_pkg::NUM_REGIONS) : CW'(r_region_count);

    assign o_done               = r_done;
    assign o_ok                 = r_ok;
    assign o_translated_address = r_taddr;

    sat_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_offset <= '0;
            r_region_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (sat_pkg::t_reg'(i_cfg_index))
                sat_pkg::REG_IMAGE_OFFSET: r_image_offset <= i_cfg_data;
                sat_pkg::REG_REGION_COUNT: r_region_count <= i_cfg_data[sat_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_idx] <= {i_entry_size, i_entry_start};
        end
        r_rd_data <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
        end else if (mem_we) begin
            r_alloc[wr_idx] <= i_entry_alloc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sat_pkg::ST_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_done  <= n_done;
            r_k     <= n_k;
        end
        r_pend_alloc <= r_alloc[rd_idx];
        r_cmd        <= n_cmd;
        r_limit      <= n_limit;
        r_faddr      <= n_faddr;
        r_addr       <= n_addr;
        r_ok         <= n_ok;
        r_taddr      <= n_taddr;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_k         = r_k;
        n_limit     = r_limit;
        n_pend      = 1'b0;
        n_faddr     = r_faddr;
        n_addr      = r_addr;
        n_done      = 1'b0;
        n_ok        = 1'b0;
        n_taddr     = '0;
        mem_we      = 1'b0;
        alu_req.op  = sat_pkg::ALU_SUB;
        alu_req.a   = r_faddr;
        alu_req.b   = r_rd_data[AW-1:0];
        alu_req.c   = r_rd_data[2*AW-1:AW];

        case (r_state)
            sat_pkg::ST_IDLE: begin
                if (accept) begin
                    n_k     = '0;
                    n_limit = limit;
                    n_addr  = i_address;
                    n_faddr = i_address;
                    case (sat_pkg::t_cmd'(i_command))
                        sat_pkg::CMD_LOAD: begin
                            mem_we = in_range;
                            n_done = 1'b1;
                            n_ok   = in_range;
                        end
                        sat_pkg::CMD_V2F: begin
                            n_cmd   = sat_pkg::CMD_V2F;
                            n_state = sat_pkg::ST_BIAS;
                        end
                        sat_pkg::CMD_F2V: begin
                            n_cmd   = sat_pkg::CMD_F2V;
                            n_state = sat_pkg::ST_SCAN;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            sat_pkg::ST_BIAS: begin
                alu_req.a = r_addr;
                alu_req.b = r_image_offset;
                if (!alu_res.carry) begin
                    n_done  = 1'b1;
                    n_state = sat_pkg::ST_IDLE;
                end else begin
                    n_faddr = alu_res.sum;
                    n_state = sat_pkg::ST_SCAN;
                end
            end
            sat_pkg::ST_SCAN: begin
                if (r_k < r_limit) begin
                    n_k    = r_k + CW'(1);
                    n_pend = 1'b1;
                end
                if (r_pend && r_pend_alloc && alu_res.carry && alu_res.below) begin
                    n_pend = 1'b0;
                    if (r_cmd == sat_pkg::CMD_F2V) begin
                        n_state = sat_pkg::ST_ADD;
                    end else begin
                        n_done  = 1'b1;
                        n_ok    = 1'b1;
                        n_taddr = r_faddr;
                        n_state = sat_pkg::ST_IDLE;
                    end
                end else if (!r_pend && (r_k >= r_limit)) begin
                    n_done  = 1'b1;
                    n_state = sat_pkg::ST_IDLE;
                end
            end
            sat_pkg::ST_ADD: begin
                alu_req.op = sat_pkg::ALU_ADD;
                alu_req.b  = r_image_offset;
                n_done     = 1'b1;
                n_ok       = 1'b1;
                n_taddr    = alu_res.sum;
                n_state    = sat_pkg::ST_IDLE;
            end
            default: begin
                n_state = sat_pkg::ST_IDLE;
            end
        endcase
    end

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_translated_address == '0))
        else $error("failed transaction returned a non-zero address");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == sat_pkg::CMD_LOAD)) |=> (o_done && !o_busy))
        else $error("load transaction did not complete in one cycle");

    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sat_pkg::ST_SCAN) |-> !o_done)
        else $error("result strobe raised during table scan");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sat_pkg::ST_SCAN) |-> (r_k <= r_limit))
        else $error("scan index ran past the search limit");

    a_pend_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_state) == sat_pkg::ST_SCAN))
        else $error("pending compare without a scan read");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for section_address_translate. Region loads, both kinds
// of translation query and unknown commands are issued in bursts, mostly
// with random gaps. A scoreboard keeps a shadow copy of the region table and
// registers, predicts each result transaction and compares it in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int         END_DRAIN   = 80;

    typedef struct {
        logic        ok;
        logic [63:0] address;
    } t_translation;

    class region_scoreboard;
        logic [63:0]  region_start [sat_pkg::NUM_REGIONS];
        logic [63:0]  region_size  [sat_pkg::NUM_REGIONS];
        logic         region_alloc [sat_pkg::NUM_REGIONS];
        logic [63:0]  image_offset;
        logic [6:0]   region_count;
        t_translation pending_translations [$];
        int           mismatch_count;

        function new();
            for (int k = 0; k < sat_pkg::NUM_REGIONS; k++) begin
                region_start[k] = '0;
                region_size[k]  = '0;
                region_alloc[k] = 1'b0;
            end
            image_offset   = '0;
            region_count   = '0;
            mismatch_count = 0;
        endfunction

        function void write_register(logic index, logic [63:0] data);
            if (index == sat_pkg::REG_IMAGE_OFFSET) begin
                image_offset = data;
            end else begin
                region_count = data[6:0];
            end
        endfunction

        function bit region_hit(logic [63:0] faddr);
            int          limit;
            logic [63:0] offset;
            limit = (region_count > sat_pkg::NUM_REGIONS) ? sat_pkg::NUM_REGIONS
                                                          : int'(region_count);
            for (int k = 0; k < limit; k++) begin
                offset = faddr - region_start[k];
                if (region_alloc[k] && faddr >= region_start[k] && offset < region_size[k])
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_command(logic [1:0] cmd, logic [5:0] index, logic [63:0] start,
                                   logic [63:0] size, logic alloc, logic [63:0] address);
            t_translation expected;
            logic [63:0]  faddr;
            expected.ok      = 1'b0;
            expected.address = '0;
            case (cmd)
                sat_pkg::CMD_LOAD: begin
                    if (index < sat_pkg::NUM_REGIONS) begin
                        region_start[index] = start;
                        region_size[index]  = size;
                        region_alloc[index] = alloc;
                        expected.ok         = 1'b1;
                    end
                end
                sat_pkg::CMD_V2F: begin
                    if (address >= image_offset) begin
                        faddr = address - image_offset;
                        if (region_hit(faddr)) begin
                            expected.ok      = 1'b1;
                            expected.address = faddr;
                        end
                    end
                end
                sat_pkg::CMD_F2V: begin
                    if (region_hit(address)) begin
                        expected.ok      = 1'b1;
                        expected.address = address + image_offset;
                    end
                end
                default: begin
                end
            endcase
            pending_translations.push_back(expected);
        endfunction

        function void check_result(logic ok, logic [63:0] address);
            t_translation expected;
            if (pending_translations.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual ok=%0b address=%h",
                         $time, ok, address);
                mismatch_count++;
            end else begin
                expected = pending_translations.pop_front();
                if (ok !== expected.ok) begin
                    $display("%0t: ok mismatch, expected %0b, actual %0b",
                             $time, expected.ok, ok);
                    mismatch_count++;
                end
                if (address !== expected.address) begin
                    $display("%0t: translated address mismatch, expected %h, actual %h",
                             $time, expected.address, address);
                    mismatch_count++;
                end
            end
        endfunction

        function int outstanding();
            return pending_translations.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_command;
    logic [5:0]  i_entry_index;
    logic [63:0] i_entry_start;
    logic [63:0] i_entry_size;
    logic        i_entry_alloc;
    logic [63:0] i_address;
    logic        o_done;
    logic        o_ok;
    logic [63:0] o_translated_address;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    region_scoreboard region_model;

    section_address_translate uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (i_start),
        .o_busy               (o_busy),
        .i_command            (i_command),
        .i_entry_index        (i_entry_index),
        .i_entry_start        (i_entry_start),
        .i_entry_size         (i_entry_size),
        .i_entry_alloc        (i_entry_alloc),
        .i_address            (i_address),
        .o_done               (o_done),
        .o_ok                 (o_ok),
        .o_translated_address (o_translated_address),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            region_model.check_result(o_ok, o_translated_address);
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] random_address();
        case ($urandom_range(0, 3))
            0, 1:    return rand64();
            2:       return 64'($urandom_range(0, 'h10000));
            default: return '1 - 64'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [63:0] random_size();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return 64'd1;
            2:       return '1;
            3, 4:    return rand64();
            default: return 64'($urandom_range(1, 4096));
        endcase
    endfunction

    // A file address at an edge of, or inside, a region entry in the shadow table.
    function automatic logic [63:0] pick_file_address();
        int          k;
        logic [63:0] base;
        logic [63:0] size;
        k    = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                    : $urandom_range(0, sat_pkg::NUM_REGIONS - 1);
        base = region_model.region_start[k];
        size = region_model.region_size[k];
        case ($urandom_range(0, 5))
            0:       return base;
            1:       return base + size - 64'd1;
            2:       return base + size;
            3:       return base - 64'd1;
            default: return (size != 0) ? base + rand64() % size : base;
        endcase
    endfunction

    task automatic send_command(input logic [1:0] cmd, input logic [5:0] index,
                                input logic [63:0] start, input logic [63:0] size,
                                input logic alloc, input logic [63:0] address);
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= index;
        i_entry_start <= start;
        i_entry_size  <= size;
        i_entry_alloc <= alloc;
        i_address     <= address;
        do @(posedge i_clk); while (o_busy);
        region_model.note_command(cmd, index, start, size, alloc, address);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (region_model.outstanding() != 0 || o_busy) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        region_model.write_register(index, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Most queries aim at region entries in the shadow table, so that hits and edge misses dominate.
    task automatic send_random_item();
        int          roll;
        logic [1:0]  cmd;
        logic [5:0]  index;
        logic [63:0] address;
        roll    = $urandom_range(0, 99);
        index   = $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
        address = rand64();
        if (roll < 30) begin
            cmd = sat_pkg::CMD_LOAD;
        end else if (roll < 62) begin
            cmd = sat_pkg::CMD_V2F;
            if ($urandom_range(0, 9) < 8)
                address = pick_file_address() + region_model.image_offset;
        end else if (roll < 94) begin
            cmd = sat_pkg::CMD_F2V;
            if ($urandom_range(0, 9) < 8)
                address = pick_file_address();
        end else begin
            cmd = CMD_UNKNOWN;
        end
        send_command(cmd, index, random_address(), random_size(),
                     $urandom_range(0, 3) != 0, address);
    endtask

    task automatic run_random_phase(input int items, input bit with_gaps);
        int burst;
        burst = $urandom_range(1, 12);
        for (int n = 0; n < items; n++) begin
            send_random_item();
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if (with_gaps)
                    pause_sender($urandom_range(0, 7) == 0 ? $urandom_range(8, 20)
                                                           : $urandom_range(1, 4));
            end
        end
    endtask

    initial begin
        logic [63:0] offset_value;
        logic [63:0] count_value;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_command     = sat_pkg::CMD_LOAD;
        i_entry_index = '0;
        i_entry_start = '0;
        i_entry_size  = '0;
        i_entry_alloc = 1'b0;
        i_address     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = sat_pkg::REG_IMAGE_OFFSET;
        i_cfg_data    = '0;
        region_model  = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset settings nothing is searched, so any query fails.
        send_command(sat_pkg::CMD_F2V, 6'd0, '0, '0, 1'b0, 64'd0);
        drain_block();
        write_register(sat_pkg::REG_IMAGE_OFFSET, 64'h1000);
        write_register(sat_pkg::REG_REGION_COUNT, 64'd4);
        send_command(sat_pkg::CMD_LOAD, 6'd0, 64'h0, 64'h100, 1'b1, '0);
        send_command(sat_pkg::CMD_LOAD, 6'd1, 64'h2000, 64'h0, 1'b1, '0);
        send_command(sat_pkg::CMD_LOAD, 6'd2, 64'h3000, 64'h10, 1'b0, '0);
        send_command(sat_pkg::CMD_LOAD, 6'd3, 64'hFFFF_FFFF_FFFF_FFF0, '1, 1'b1, '0);
        send_command(sat_pkg::CMD_LOAD, 6'd63, 64'h5000, 64'h100, 1'b1, '0);
        send_command(sat_pkg::CMD_V2F, 6'd0, '0, '0, 1'b0, 64'h1000);
        send_command(sat_pkg::CMD_V2F, 6'd0, '0, '0, 1'b0, 64'h0FFF);
        send_command(sat_pkg::CMD_V2F, 6'd0, '0, '0, 1'b0, 64'h1100);
        send_command(sat_pkg::CMD_V2F, 6'd0, '0, '0, 1'b0, 64'h4000);
        send_command(sat_pkg::CMD_F2V, 6'd0, '0, '0, 1'b0, 64'h2000);
        send_command(sat_pkg::CMD_F2V, 6'd0, '0, '0, 1'b0, '1);
        send_command(sat_pkg::CMD_F2V, 6'd0, '0, '0, 1'b0, 64'h5000);
        send_command(CMD_UNKNOWN, 6'd63, '1, '1, 1'b1, '1);
        send_command(sat_pkg::CMD_F2V, 6'd0, '0, '0, 1'b0, 64'h0);

        // A count above the table depth searches the whole table.
        drain_block();
        write_register(sat_pkg::REG_IMAGE_OFFSET, '1);
        write_register(sat_pkg::REG_REGION_COUNT, 64'd127);
        send_command(sat_pkg::CMD_F2V, 6'd0, '0, '0, 1'b0, 64'h5000);
        send_command(sat_pkg::CMD_V2F, 6'd0, '0, '0, 1'b0, '1);
        send_command(sat_pkg::CMD_V2F, 6'd0, '0, '0, 1'b0, 64'h0);
        send_command(sat_pkg::CMD_LOAD, 6'd63, 64'h5000, 64'h100, 1'b0, '0);
        send_command(sat_pkg::CMD_F2V, 6'd0, '0, '0, 1'b0, 64'h5000);

        drain_block();
        write_register(sat_pkg::REG_IMAGE_OFFSET, 64'h0);
        write_register(sat_pkg::REG_REGION_COUNT, 64'hFFFF_FFFF_FFFF_FFC0);
        send_command(sat_pkg::CMD_F2V, 6'd0, '0, '0, 1'b0, 64'h10);
        send_command(sat_pkg::CMD_V2F, 6'd0, '0, '0, 1'b0, 64'hFFFF_FFFF_FFFF_FFF5);
        send_command(sat_pkg::CMD_V2F, 6'd0, '0, '0, 1'b0, 64'h2000);

        for (int phase = 0; phase < 5; phase++) begin
            drain_block();
            case ($urandom_range(0, 3))
                0:       offset_value = '0;
                1:       offset_value = '1;
                2:       offset_value = 64'($urandom_range(0, 'h10000));
                default: offset_value = rand64();
            endcase
            count_value = rand64();
            case ($urandom_range(0, 4))
                0:       count_value[6:0] = 7'd64;
                1:       count_value[6:0] = 7'd127;
                2:       count_value[6:0] = 7'($urandom_range(0, 127));
                default: count_value[6:0] = 7'($urandom_range(1, 12));
            endcase
            write_register(sat_pkg::REG_IMAGE_OFFSET, offset_value);
            write_register(sat_pkg::REG_REGION_COUNT, count_value);
            run_random_phase(100, phase != 2);
        end

        drain_block();
        repeat (END_DRAIN) @(posedge i_clk);
        if (region_model.mismatch_count == 0 && region_model.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
